// ----- rtl/bmm_pkg.sv -----
package bmm_pkg;

    localparam int VIDEO_BANKS = 2;
    localparam int WORK_BANKS  = 8;

    localparam int VIDEO_BANK_BYTES = 8192;
    localparam int WORK_BANK_BYTES  = 4096;
    localparam int VIDEO_DEPTH      = VIDEO_BANKS * VIDEO_BANK_BYTES;
    localparam int WORK_DEPTH       = WORK_BANKS * WORK_BANK_BYTES;
    localparam int VIDEO_AW         = $clog2(VIDEO_DEPTH);
    localparam int WORK_AW          = $clog2(WORK_DEPTH);
    localparam int UPPER_DEPTH      = 512;
    localparam int UPPER_AW         = $clog2(UPPER_DEPTH);
    localparam int PAL_DEPTH        = 64;
    localparam int PAL_AW           = $clog2(PAL_DEPTH);

    localparam logic [15:0] UPPER_BASE = 16'hFE00;
    localparam logic [15:0] OAM_LAST   = 16'hFE9F;
    localparam logic [15:0] REG_DIV    = 16'hFF04;
    localparam logic [15:0] REG_LY     = 16'hFF44;
    localparam logic [15:0] REG_DMA    = 16'hFF46;
    localparam logic [15:0] REG_VBK    = 16'hFF4F;
    localparam logic [15:0] REG_BGIDX  = 16'hFF68;
    localparam logic [15:0] REG_BGDAT  = 16'hFF69;
    localparam logic [15:0] REG_OBIDX  = 16'hFF6A;
    localparam logic [15:0] REG_OBDAT  = 16'hFF6B;
    localparam logic [15:0] REG_SVBK   = 16'hFF70;

    localparam logic [7:0] PAL_RESET = 8'hFF;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_VIDEO,
        SRC_WORK,
        SRC_UPPER,
        SRC_BGPAL,
        SRC_OBPAL,
        SRC_BGIDX,
        SRC_OBIDX
    } t_src;

    typedef struct packed {
        t_src src;
        logic cart;
        logic we_video;
        logic we_work;
        logic we_upper;
        logic upper_zero;
        logic set_vbk;
        logic set_svbk;
        logic set_bgidx;
        logic set_obidx;
        logic we_bgpal;
        logic we_obpal;
    } t_dec;

endpackage

// ----- rtl/bmm_if.sv -----
interface bmm_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        vram_allowed;
    logic        oam_allowed;
    logic        palette_allowed;

    modport source (
        output valid, command, address, write_data, vram_allowed, oam_allowed,
               palette_allowed,
        input  ready
    );
    modport sink (
        input  valid, command, address, write_data, vram_allowed, oam_allowed,
               palette_allowed,
        output ready
    );
endinterface

interface bmm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       to_cartridge;

    modport source (
        output valid, read_data, to_cartridge,
        input  ready
    );
    modport sink (
        input  valid, read_data, to_cartridge,
        output ready
    );
endinterface

// ----- rtl/bmm_ram.sv -----
module bmm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bmm_decode.sv -----
module bmm_decode (
    input  logic          i_command,
    input  logic [15:0]   i_address,
    input  logic          i_vram_allowed,
    input  logic          i_oam_allowed,
    input  logic          i_palette_allowed,
    output bmm_pkg::t_dec o_dec
);
    import bmm_pkg::*;

    logic   wr;
    logic   rd;
    logic   is_upper;
    t_dec   dec;

    assign wr       = i_command;
    assign rd       = !i_command;
    assign is_upper = (i_address >= UPPER_BASE);

    always_comb begin
        dec = '0;
        dec.src = SRC_ZERO;
        unique case (i_address[15:12]) inside
            [4'h0:4'h7], 4'hA, 4'hB: begin
                dec.cart = 1'b1;
            end
            4'h8, 4'h9: begin
                dec.we_video = wr && i_vram_allowed;
                if (rd) dec.src = SRC_VIDEO;
            end
            4'hC, 4'hD, 4'hE: begin
                dec.we_work = wr;
                if (rd) dec.src = SRC_WORK;
            end
            default: begin
                if (!is_upper) begin
                    dec.we_work = wr;
                    if (rd) dec.src = SRC_WORK;
                end else if (rd) begin
                    unique case (i_address)
                        REG_BGIDX: dec.src = SRC_BGIDX;
                        REG_OBIDX: dec.src = SRC_OBIDX;
                        REG_BGDAT: dec.src = i_palette_allowed ? SRC_BGPAL : SRC_ZERO;
                        REG_OBDAT: dec.src = i_palette_allowed ? SRC_OBPAL : SRC_ZERO;
                        default:   dec.src = SRC_UPPER;
                    endcase
                end else if (i_address <= OAM_LAST) begin
                    dec.we_upper = i_oam_allowed;
                end else begin
                    unique case (i_address)
                        REG_DIV: begin
                            dec.we_upper   = 1'b1;
                            dec.upper_zero = 1'b1;
                        end
                        REG_LY, REG_DMA: begin
                            dec.we_upper = 1'b0;
                        end
                        REG_VBK: begin
                            dec.we_upper = 1'b1;
                            dec.set_vbk  = 1'b1;
                        end
                        REG_SVBK: begin
                            dec.we_upper = 1'b1;
                            dec.set_svbk = 1'b1;
                        end
                        REG_BGIDX: begin
                            dec.we_upper  = 1'b1;
                            dec.set_bgidx = 1'b1;
                        end
                        REG_OBIDX: begin
                            dec.we_upper  = 1'b1;
                            dec.set_obidx = 1'b1;
                        end
                        REG_BGDAT: dec.we_bgpal = i_palette_allowed;
                        REG_OBDAT: dec.we_obpal = i_palette_allowed;
                        default:   dec.we_upper = 1'b1;
                    endcase
                end
            end
        endcase
    end

    assign o_dec = dec;
endmodule

// ----- rtl/banked_memory_map.sv -----
// Channel  Modport            Transfer carries
// i_req    bmm_req_if.sink    command, address, write_data, vram/oam/palette allowed
// o_rsp    bmm_rsp_if.source  read_data, to_cartridge (one per request)
//
// One request per cycle while o_rsp is not stalled; a response passes through the access stage and the output register.
// Each request performs its memory access at its transfer edge, so a bank,
// index or RAM write steers the very next request; RAM reads are registered.
// Reset: synchronous, active low; palette entries read 0xFF until written.
// A stalled o_rsp holds the output register, then the access stage, then i_req.
module banked_memory_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmm_req_if.sink        i_req,
    bmm_rsp_if.source      o_rsp
);
    import bmm_pkg::*;

    t_dec                  dec;
    logic                  accept;
    logic                  adv;
    logic [13:0]           video_full;
    logic [14:0]           work_full;
    logic [2:0]            work_sel;
    logic [VIDEO_AW-1:0]   video_addr;
    logic [WORK_AW-1:0]    work_addr;
    logic [UPPER_AW-1:0]   upper_addr;
    logic [7:0]            upper_wdata;
    logic [7:0]            video_rdata;
    logic [7:0]            work_rdata;
    logic [7:0]            upper_rdata;
    logic [7:0]            bgpal_rdata;
    logic [7:0]            obpal_rdata;
    logic [7:0]            s1_data;

    logic                  r_video_bank;
    logic [2:0]            r_work_bank;
    logic [7:0]            r_bg_idx;
    logic [7:0]            r_ob_idx;
    logic [PAL_DEPTH-1:0]  r_bg_pv;
    logic [PAL_DEPTH-1:0]  r_ob_pv;
    logic                  r_s1_valid;
    t_src                  r_s1_src;
    logic                  r_s1_cart;
    logic                  r_s1_pv;
    logic                  r_o_valid;
    logic [7:0]            r_o_data;
    logic                  r_o_cart;

    logic                  n_video_bank;
    logic [2:0]            n_work_bank;
    logic [7:0]            n_bg_idx;
    logic [7:0]            n_ob_idx;

    bmm_decode u_decode (
        .i_command         (i_req.command),
        .i_address         (i_req.address),
        .i_vram_allowed    (i_req.vram_allowed),
        .i_oam_allowed     (i_req.oam_allowed),
        .i_palette_allowed (i_req.palette_allowed),
        .o_dec             (dec)
    );

    assign adv         = !r_o_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || adv;
    assign accept      = i_req.valid && i_req.ready;

    assign video_full  = {r_video_bank, i_req.address[12:0]};
    assign video_addr  = video_full[VIDEO_AW-1:0];
    assign work_sel    = i_req.address[12] ? r_work_bank : 3'd0;
    assign work_full   = {work_sel, i_req.address[11:0]};
    assign work_addr   = work_full[WORK_AW-1:0];
    assign upper_addr  = i_req.address[UPPER_AW-1:0];
    assign upper_wdata = dec.upper_zero ? 8'd0 : i_req.write_data;

    bmm_ram #(.DEPTH(VIDEO_DEPTH), .WIDTH(8)) u_video (
        .i_clk   (i_clk),
        .i_we    (accept && dec.we_video),
        .i_re    (accept && (dec.src == SRC_VIDEO)),
        .i_addr  (video_addr),
        .i_wdata (i_req.write_data),
        .o_rdata (video_rdata)
    );

    bmm_ram #(.DEPTH(WORK_DEPTH), .WIDTH(8)) u_work (
        .i_clk   (i_clk),
        .i_we    (accept && dec.we_work),
        .i_re    (accept && (dec.src == SRC_WORK)),
        .i_addr  (work_addr),
        .i_wdata (i_req.write_data),
        .o_rdata (work_rdata)
    );

    bmm_ram #(.DEPTH(UPPER_DEPTH), .WIDTH(8)) u_upper (
        .i_clk   (i_clk),
        .i_we    (accept && dec.we_upper),
        .i_re    (accept && (dec.src == SRC_UPPER)),
        .i_addr  (upper_addr),
        .i_wdata (upper_wdata),
        .o_rdata (upper_rdata)
    );

    bmm_ram #(.DEPTH(PAL_DEPTH), .WIDTH(8)) u_bgpal (
        .i_clk   (i_clk),
        .i_we    (accept && dec.we_bgpal),
        .i_re    (accept && (dec.src == SRC_BGPAL)),
        .i_addr  (r_bg_idx[PAL_AW-1:0]),
        .i_wdata (i_req.write_data),
        .o_rdata (bgpal_rdata)
    );

    bmm_ram #(.DEPTH(PAL_DEPTH), .WIDTH(8)) u_obpal (
        .i_clk   (i_clk),
        .i_we    (accept && dec.we_obpal),
        .i_re    (accept && (dec.src == SRC_OBPAL)),
        .i_addr  (r_ob_idx[PAL_AW-1:0]),
        .i_wdata (i_req.write_data),
        .o_rdata (obpal_rdata)
    );

    always_comb begin
        n_video_bank = r_video_bank;
        n_work_bank  = r_work_bank;
        n_bg_idx     = r_bg_idx;
        n_ob_idx     = r_ob_idx;
        if (dec.set_vbk) begin
            n_video_bank = (int'(i_req.write_data[0]) < VIDEO_BANKS) ?
                           i_req.write_data[0] : 1'b0;
        end
        if (dec.set_svbk) begin
            if (i_req.write_data[2:0] == 3'd0) begin
                n_work_bank = 3'd1;
            end else if (int'(i_req.write_data[2:0]) >= WORK_BANKS) begin
                n_work_bank = 3'(WORK_BANKS - 1);
            end else begin
                n_work_bank = i_req.write_data[2:0];
            end
        end
        if (dec.set_bgidx) begin
            n_bg_idx = i_req.write_data;
        end else if (dec.we_bgpal && r_bg_idx[7]) begin
            n_bg_idx = {2'b10, r_bg_idx[5:0] + 6'd1};
        end
        if (dec.set_obidx) begin
            n_ob_idx = i_req.write_data;
        end else if (dec.we_obpal && r_ob_idx[7]) begin
            n_ob_idx = {2'b10, r_ob_idx[5:0] + 6'd1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_bank <= 1'b0;
            r_work_bank  <= 3'd1;
            r_bg_idx     <= 8'd0;
            r_ob_idx     <= 8'd0;
            r_bg_pv      <= '0;
            r_ob_pv      <= '0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_video_bank <= n_video_bank;
                r_work_bank  <= n_work_bank;
                r_bg_idx     <= n_bg_idx;
                r_ob_idx     <= n_ob_idx;
                if (dec.we_bgpal) r_bg_pv[r_bg_idx[PAL_AW-1:0]] <= 1'b1;
                if (dec.we_obpal) r_ob_pv[r_ob_idx[PAL_AW-1:0]] <= 1'b1;
            end
            if (i_req.ready) begin
                r_s1_valid <= accept;
            end
            if (r_s1_valid && adv) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_VIDEO: s1_data = video_rdata;
            SRC_WORK:  s1_data = work_rdata;
            SRC_UPPER: s1_data = upper_rdata;
            SRC_BGPAL: s1_data = r_s1_pv ? bgpal_rdata : PAL_RESET;
            SRC_OBPAL: s1_data = r_s1_pv ? obpal_rdata : PAL_RESET;
            SRC_BGIDX: s1_data = r_bg_idx;
            SRC_OBIDX: s1_data = r_ob_idx;
            default:   s1_data = 8'd0;
        endcase
    end

    // index registers only change on writes, so they still hold the read value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src  <= dec.src;
            r_s1_cart <= dec.cart;
            r_s1_pv   <= (dec.src == SRC_BGPAL) ? r_bg_pv[r_bg_idx[PAL_AW-1:0]] :
                                                  r_ob_pv[r_ob_idx[PAL_AW-1:0]];
        end
        if (r_s1_valid && adv) begin
            r_o_data <= s1_data;
            r_o_cart <= r_s1_cart;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.read_data    = r_o_data;
    assign o_rsp.to_cartridge = r_o_cart;
endmodule
